// ===== src/delta_list_task_timer_queue_top_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef DELTA_LIST_TASK_TIMER_QUEUE_TOP_MACROS_SVH
`define DELTA_LIST_TASK_TIMER_QUEUE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define DLTQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dltq assertion failed");
`define DLTQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("dltq assertion failed");
`else
`define DLTQ_ASSERT(lbl, prop)
`define DLTQ_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== src/dltq_pkg.sv =====
`timescale 1ns / 1ps
package dltq_pkg;
  localparam int SLOTS = 16;
  localparam int IDXW = $clog2(SLOTS);
  localparam int IW = $clog2(SLOTS + 1);
  localparam int CW = 32 + IDXW + 1;
  localparam int CMPW = (IW > 5) ? IW : 5;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

  typedef struct packed {
    logic          valid;
    logic          ready;
    logic [IW-1:0] ident;
    logic [31:0]   tag;
    logic [31:0]   arg;
    logic [31:0]   delta;
    logic [31:0]   period;
  } slot_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_TICK,
    CMD_INS,
    CMD_DEL,
    CMD_REIN
  } cmd_e;

  typedef struct packed {
    cmd_e            kind;
    logic [IDXW-1:0] idx;
    logic            split;
    logic [31:0]     split_delta;
    logic [15:0]     step;
    slot_t           fill;
  } cmd_t;
endpackage

// ===== src/dltq_if.sv =====
`timescale 1ns / 1ps
interface dltq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] task_tag;
  logic [31:0] task_arg;
  logic [31:0] start_delay;
  logic [31:0] repeat_period;
  logic [4:0]  target_id;
  modport source(output valid, opcode, task_tag, task_arg, start_delay, repeat_period,
                 target_id, input ready);
  modport sink(input valid, opcode, task_tag, task_arg, start_delay, repeat_period,
               target_id, output ready);
endinterface

interface dltq_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [4:0]  given_id;
  logic        fired;
  logic [31:0] fired_tag;
  logic [31:0] fired_arg;
  modport source(output valid, status, given_id, fired, fired_tag, fired_arg, input ready);
  modport sink(input valid, status, given_id, fired, fired_tag, fired_arg, output ready);
endinterface

interface dltq_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== src/dltq_cell.sv =====
`timescale 1ns / 1ps
module dltq_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [dltq_pkg::IDXW-1:0]    pos_i,
  input  dltq_pkg::cmd_t               cmd_i,
  input  dltq_pkg::slot_t              prev_i,
  input  dltq_pkg::slot_t              next_i,
  output dltq_pkg::slot_t              slot_o
);
  dltq_pkg::slot_t slot_q, slot_d, slot_rst;
  logic [dltq_pkg::IDXW:0] pos_x, idx_x;
  logic [31:0] tick_val;

  assign pos_x = {1'b0, pos_i};
  assign idx_x = {1'b0, cmd_i.idx};
  assign tick_val = (slot_q.delta > 32'(cmd_i.step)) ? slot_q.delta - 32'(cmd_i.step) : '0;

  // empty slot holding its share of the free id pool
  always_comb begin
    slot_rst = '0;
    slot_rst.ident = dltq_pkg::IW'(dltq_pkg::SLOTS) - dltq_pkg::IW'(pos_i);
  end

  always_comb begin
    slot_d = slot_q;
    case (cmd_i.kind)
      dltq_pkg::CMD_TICK: begin
        if (pos_i == '0 && slot_q.valid) begin
          slot_d.delta = tick_val;
          slot_d.ready = slot_q.ready | (tick_val == '0);
        end
      end
      dltq_pkg::CMD_INS: begin
        if (pos_i == cmd_i.idx) begin
          slot_d = cmd_i.fill;
        end else if (pos_i > cmd_i.idx) begin
          slot_d = prev_i;
          if (cmd_i.split && pos_x == idx_x + 1'b1) begin
            slot_d.delta = cmd_i.split_delta;
            slot_d.ready = prev_i.ready | (cmd_i.split_delta == '0);
          end
        end
      end
      dltq_pkg::CMD_DEL: begin
        if (pos_i >= cmd_i.idx) begin
          if (pos_i == dltq_pkg::LAST_IDX) begin
            slot_d = '0;
            slot_d.ident = cmd_i.fill.ident;
          end else begin
            slot_d = next_i;
            if (pos_i == cmd_i.idx && next_i.valid) begin
              slot_d.delta = next_i.delta + slot_q.delta;
            end
          end
        end
      end
      dltq_pkg::CMD_REIN: begin
        if (pos_i < cmd_i.idx) begin
          slot_d = next_i;
        end else if (pos_i == cmd_i.idx) begin
          slot_d = cmd_i.fill;
        end else if (cmd_i.split && pos_x == idx_x + 1'b1) begin
          slot_d.delta = cmd_i.split_delta;
          slot_d.ready = slot_q.ready | (cmd_i.split_delta == '0);
        end
      end
      default: begin
        slot_d = slot_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= slot_rst;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;
endmodule

// ===== src/delta_list_task_timer_queue_top.sv =====
`timescale 1ns / 1ps
// Sorted delta-list timer queue built as a row of SLOTS slot cells. A tick and a one-shot
// dispatch pass from the accepted word through the run and done states to the output
// register; add, delete and periodic dispatch walk the row one slot per cycle, add and
// periodic dispatch with a running time sum, and all cells then shift or load at once.
// One request is handled at a time, and the next one is taken while the previous result
// still waits in the output register.
`include "delta_list_task_timer_queue_top_macros.svh"
module delta_list_task_timer_queue_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  dltq_req_if.sink   req_i,
  dltq_rsp_if.source rsp_o,
  dltq_cfg_if.sink   cfg_i
);
  typedef enum logic [1:0] {OP_TICK, OP_ADD, OP_DEL, OP_DISP} op_e;
  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_e;

  state_e state_q;
  op_e op_q;
  logic [31:0] tag_q, arg_q, delay_q, period_q;
  logic [4:0] target_q;
  logic [15:0] tick_step_q;
  logic [dltq_pkg::IDXW-1:0] w_q, w_d, rd_idx;
  logic [dltq_pkg::CW-1:0] cum_q, cum_d, sum, delay_x;
  logic fin, res_status, res_fired;
  logic [4:0] res_gid;
  logic [31:0] res_tag, res_arg, rest;
  logic st_q, fired_q, rs_status_q, rs_fired_q;
  logic [4:0] gid_q, rs_gid_q;
  logic [31:0] ftag_q, farg_q, rs_tag_q, rs_arg_q;
  logic out_valid_q;
  dltq_pkg::cmd_t cmd;
  dltq_pkg::slot_t slots [dltq_pkg::SLOTS];
  dltq_pkg::slot_t prev_w [dltq_pkg::SLOTS];
  dltq_pkg::slot_t next_w [dltq_pkg::SLOTS];
  dltq_pkg::slot_t rd, s0, sl;
  logic [dltq_pkg::SLOTS-1:0] vld_w;

  for (genvar g = 0; g < dltq_pkg::SLOTS; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev_w[g] = '0;
    end else begin : g_mid
      assign prev_w[g] = slots[g-1];
    end
    if (g == dltq_pkg::SLOTS - 1) begin : g_last
      assign next_w[g] = '0;
    end else begin : g_nxt
      assign next_w[g] = slots[g+1];
    end
    assign vld_w[g] = slots[g].valid;
    dltq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pos_i  (dltq_pkg::IDXW'(g)),
      .cmd_i  (cmd),
      .prev_i (prev_w[g]),
      .next_i (next_w[g]),
      .slot_o (slots[g])
    );
  end

  assign s0 = slots[0];
  assign sl = slots[dltq_pkg::SLOTS-1];
  assign rd_idx = (op_q == OP_DISP) ? w_q + 1'b1 : w_q;
  assign rd = slots[rd_idx];
  assign sum = cum_q + dltq_pkg::CW'(rd.delta);
  assign delay_x = dltq_pkg::CW'(delay_q);

  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cmd = '0;
    cmd.kind = dltq_pkg::CMD_HOLD;
    cmd.step = tick_step_q;
    fin = 1'b0;
    res_status = 1'b0;
    res_gid = '0;
    res_fired = 1'b0;
    res_tag = '0;
    res_arg = '0;
    w_d = w_q;
    cum_d = cum_q;
    rest = '0;
    if (state_q == ST_RUN) begin
      case (op_q)
        OP_TICK: begin
          cmd.kind = dltq_pkg::CMD_TICK;
          fin = 1'b1;
        end
        OP_ADD: begin
          rest = 32'(sum - delay_x);
          if (sl.valid) begin
            fin = 1'b1;
            res_status = 1'b1;
          end else if (sum > delay_x || !rd.valid) begin
            fin = 1'b1;
            cmd.kind = dltq_pkg::CMD_INS;
            cmd.idx = w_q;
            cmd.split = (sum > delay_x) && (w_q != dltq_pkg::LAST_IDX);
            cmd.split_delta = rest;
            cmd.fill.valid = 1'b1;
            cmd.fill.ident = sl.ident;
            cmd.fill.tag = tag_q;
            cmd.fill.arg = arg_q;
            cmd.fill.period = period_q;
            cmd.fill.delta = cmd.split ? rd.delta - rest : 32'(delay_x - sum);
            cmd.fill.ready = (cmd.fill.delta == '0);
            res_gid = 5'(sl.ident);
          end else if (w_q == dltq_pkg::LAST_IDX) begin
            fin = 1'b1;
            res_status = 1'b1;
          end else begin
            w_d = w_q + 1'b1;
            cum_d = sum;
          end
        end
        OP_DEL: begin
          if (!rd.valid) begin
            fin = 1'b1;
            res_status = 1'b1;
          end else if (dltq_pkg::CMPW'(rd.ident) == dltq_pkg::CMPW'(target_q)) begin
            fin = 1'b1;
            cmd.kind = dltq_pkg::CMD_DEL;
            cmd.idx = w_q;
            cmd.fill.ident = rd.ident;
          end else if (w_q == dltq_pkg::LAST_IDX) begin
            fin = 1'b1;
            res_status = 1'b1;
          end else begin
            w_d = w_q + 1'b1;
          end
        end
        default: begin
          res_fired = s0.valid & s0.ready;
          res_gid = res_fired ? 5'(s0.ident) : '0;
          res_tag = res_fired ? s0.tag : '0;
          res_arg = res_fired ? s0.arg : '0;
          rest = 32'(sum - dltq_pkg::CW'(s0.period));
          cmd.fill.valid = 1'b1;
          cmd.fill.ident = s0.ident;
          cmd.fill.tag = s0.tag;
          cmd.fill.arg = s0.arg;
          cmd.fill.period = s0.period;
          cmd.idx = w_q;
          if (!res_fired) begin
            fin = 1'b1;
            res_status = 1'b1;
          end else if (s0.period == '0) begin
            fin = 1'b1;
            cmd.kind = dltq_pkg::CMD_DEL;
            cmd.idx = '0;
          end else if (w_q == dltq_pkg::LAST_IDX || !rd.valid) begin
            fin = 1'b1;
            cmd.kind = dltq_pkg::CMD_REIN;
            cmd.fill.delta = 32'(dltq_pkg::CW'(s0.period) - cum_q);
            cmd.fill.ready = (cmd.fill.delta == '0);
          end else if (sum > dltq_pkg::CW'(s0.period)) begin
            fin = 1'b1;
            cmd.kind = dltq_pkg::CMD_REIN;
            cmd.split = 1'b1;
            cmd.split_delta = rest;
            cmd.fill.delta = rd.delta - rest;
            cmd.fill.ready = (cmd.fill.delta == '0);
          end else begin
            w_d = w_q + 1'b1;
            cum_d = sum;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
      tick_step_q <= 16'd10;
      op_q <= OP_TICK;
      w_q <= '0;
      cum_q <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        tick_step_q <= cfg_i.data;
      end
      if (rsp_o.valid && rsp_o.ready && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            op_q <= op_e'(req_i.opcode);
            tag_q <= req_i.task_tag;
            arg_q <= req_i.task_arg;
            delay_q <= req_i.start_delay;
            period_q <= req_i.repeat_period;
            target_q <= req_i.target_id;
            w_q <= '0;
            cum_q <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          w_q <= w_d;
          cum_q <= cum_d;
          if (fin) begin
            rs_status_q <= res_status;
            rs_gid_q <= res_gid;
            rs_fired_q <= res_fired;
            rs_tag_q <= res_tag;
            rs_arg_q <= res_arg;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || rsp_o.ready) begin
            st_q <= rs_status_q;
            gid_q <= rs_gid_q;
            fired_q <= rs_fired_q;
            ftag_q <= rs_tag_q;
            farg_q <= rs_arg_q;
            out_valid_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.status = st_q;
  assign rsp_o.given_id = gid_q;
  assign rsp_o.fired = fired_q;
  assign rsp_o.fired_tag = ftag_q;
  assign rsp_o.fired_arg = farg_q;

  `DLTQ_ASSERT(a_no_holes, ((vld_w >> 1) & ~vld_w) == '0)
  `DLTQ_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
  `DLTQ_ASSERT(a_accept_starts, (req_i.valid && req_i.ready) |=> state_q == ST_RUN)
endmodule
